// ===== sv/loglog_register_store_max_update_assert.svh =====
// Assertion macros for the register store, with an empty fallback when assertions are off.
`ifndef LOGLOG_REGISTER_STORE_MAX_UPDATE_ASSERT_SVH
`define LOGLOG_REGISTER_STORE_MAX_UPDATE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check prop at every clock edge outside reset.
`define LLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that post holds in the cycle after pre.
`define LLS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define LLS_ASSERT(lbl, prop, msg)
`define LLS_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ===== sv/lls_pkg.sv =====
// Shared types and constants of the register store.
package lls_pkg;

  localparam int IN_INDEX_W  = 14;
  localparam int IN_RANK_W   = 6;
  localparam int OUT_VALUE_W = 6;
  localparam int STATUS_W    = 2;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 8;

  localparam logic ACT_READ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_ABSENT = 2'd1,
    STS_FULL   = 2'd2
  } status_t;

  typedef struct packed {
    logic clear;      // zero one dense word, advance sweep
    logic accept;     // latch request, start memory reads
    logic dense_upd;  // dense read-modify-write and result
    logic scan;       // examine one sparse entry
    logic flush;      // move held result to output register
  } cmd_t;

  typedef struct packed {
    logic list_sel;
    logic clear_last;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/lls_ctrl.sv =====
// Controller state machine of the register store.
module lls_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lls_pkg::sts_t sts,
  output lls_pkg::cmd_t cmd
);
  import lls_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DENSE = 5'b00100,
    S_SCAN  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.list_sel ? S_SCAN : S_DENSE;
        end
      end
      S_DENSE: begin
        cmd.dense_upd = 1'b1;
        state_next    = sts.out_free ? S_IDLE : S_RESP;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = sts.out_free ? S_IDLE : S_RESP;
      end
      S_RESP: begin
        cmd.flush = 1'b1;
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== sv/lls_datapath.sv =====
// Datapath of the register store: memories, scan counters, result and output registers.
module lls_datapath #(
  parameter int INDEX_BITS   = 14,
  parameter int VALUE_BITS   = 6,
  parameter int SPARSE_DEPTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lls_pkg::cmd_t                       cmd,
  output lls_pkg::sts_t                       sts,
  input  logic                                in_action,
  input  logic [lls_pkg::IN_INDEX_W-1:0]      in_index,
  input  logic [lls_pkg::IN_RANK_W-1:0]       in_rank,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lls_pkg::OUT_VALUE_W-1:0]     out_value,
  output lls_pkg::status_t                    out_status
);
  import lls_pkg::*;

  localparam int SA = (SPARSE_DEPTH > 1) ? $clog2(SPARSE_DEPTH) : 1;
  localparam int CW = $clog2(SPARSE_DEPTH + 1);
  localparam int EW = INDEX_BITS + VALUE_BITS;

  logic [INDEX_BITS-1:0] in_idx;
  logic [VALUE_BITS-1:0] in_val;
  assign in_idx = INDEX_BITS'({16'd0, in_index});
  assign in_val = VALUE_BITS'({8'd0, in_rank});

  logic                  store_mode;
  logic                  req_read;
  logic [INDEX_BITS-1:0] req_idx;
  logic [VALUE_BITS-1:0] req_val;
  logic [INDEX_BITS-1:0] clear_addr;
  logic [CW-1:0]         sparse_count;
  logic [CW-1:0]         scan_addr;

  logic [VALUE_BITS-1:0] dense_mem [2**INDEX_BITS];
  logic [VALUE_BITS-1:0] dense_rd;
  logic [EW-1:0]         sparse_mem [SPARSE_DEPTH];
  logic [EW-1:0]         sparse_rd;

  logic [VALUE_BITS-1:0] pend_value;
  status_t               pend_status;
  logic [VALUE_BITS-1:0] res_value;
  status_t               res_status;

  logic [INDEX_BITS-1:0] s_idx;
  logic [VALUE_BITS-1:0] s_val, cur_val, new_val;
  logic                  at_end, hit, full, raise, finish, out_free;
  logic                  dense_we, sparse_we, append;
  logic [INDEX_BITS-1:0] dense_waddr;
  logic [VALUE_BITS-1:0] dense_wdata;
  logic [CW-1:0]         sparse_raddr;

  assign s_idx   = sparse_rd[EW-1:VALUE_BITS];
  assign s_val   = sparse_rd[VALUE_BITS-1:0];
  assign at_end  = (scan_addr == sparse_count);
  assign hit     = !at_end && (s_idx == req_idx);
  assign full    = (sparse_count == CW'(SPARSE_DEPTH));
  assign cur_val = cmd.dense_upd ? dense_rd : s_val;
  assign raise   = (req_read != ACT_READ) && (req_val > cur_val);
  assign new_val = raise ? req_val : cur_val;
  assign finish  = cmd.dense_upd || (cmd.scan && (hit || at_end));
  assign append  = cmd.scan && at_end && (req_read != ACT_READ) && !full;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    if (cmd.dense_upd || hit) begin
      res_value  = new_val;
      res_status = STS_OK;
    end else if (req_read == ACT_READ) begin
      res_value  = '0;
      res_status = STS_ABSENT;
    end else if (full) begin
      res_value  = '0;
      res_status = STS_FULL;
    end else begin
      res_value  = req_val;
      res_status = STS_OK;
    end
  end

  // Clear sweep owns the dense write port after reset.
  assign dense_we    = cmd.clear || (cmd.dense_upd && raise);
  assign dense_waddr = cmd.clear ? clear_addr : req_idx;
  assign dense_wdata = cmd.clear ? '0 : req_val;

  // A hit and an append both write at scan_addr: on an append it equals the count.
  assign sparse_we    = (cmd.scan && hit && raise) || append;
  assign sparse_raddr = cmd.accept ? '0 : scan_addr + 1'b1;

  always_ff @(posedge clk) begin
    if (dense_we) dense_mem[dense_waddr] <= dense_wdata;
    if (cmd.accept) dense_rd <= dense_mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (sparse_we) sparse_mem[scan_addr[SA-1:0]] <= {req_idx, req_val};
    if (cmd.accept || cmd.scan) sparse_rd <= sparse_mem[sparse_raddr[SA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_mode   <= 1'b0;
      clear_addr   <= '0;
      sparse_count <= '0;
      scan_addr    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) store_mode <= cfg_wr_data;
      if (cmd.clear) clear_addr <= clear_addr + 1'b1;
      if (append) sparse_count <= sparse_count + 1'b1;
      if (cmd.accept) begin
        scan_addr <= '0;
      end else if (cmd.scan && !hit && !at_end) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if ((finish || cmd.flush) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_read <= in_action;
      req_idx  <= in_idx;
      req_val  <= in_val;
    end
    if (finish && !out_free) begin
      pend_value  <= res_value;
      pend_status <= res_status;
    end
    if (out_free) begin
      if (finish) begin
        out_value  <= OUT_VALUE_W'({{OUT_VALUE_W{1'b0}}, res_value});
        out_status <= res_status;
      end else if (cmd.flush) begin
        out_value  <= OUT_VALUE_W'({{OUT_VALUE_W{1'b0}}, pend_value});
        out_status <= pend_status;
      end
    end
  end

  assign sts.list_sel    = store_mode;
  assign sts.clear_last  = &clear_addr;
  assign sts.scan_done   = hit || at_end;
  assign sts.out_free    = out_free;

endmodule

// ===== sv/loglog_register_store_max_update.sv =====
// Dense clear sweep after reset; s_tready stays low during it, config writes taken.
// Dense mode: each beat takes a registered memory read, then a max compare and write back.
// Sparse mode: each beat scans the list, one list entry per cycle through the memory port.
// Reset is synchronous, active high; it zeroes the dense store, list count and store_mode.
module loglog_register_store_max_update #(
  parameter int INDEX_BITS   = 14,
  parameter int VALUE_BITS   = 6,
  parameter int SPARSE_DEPTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  // input beats
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lls_pkg::S_TDATA_W-1:0]     s_tdata,   // reg_index[13:0], rank_value[19:14], zero
  input  logic [0:0]                        s_tuser,   // action (0 update, 1 read)
  // result beats
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lls_pkg::M_TDATA_W-1:0]     m_tdata,   // read_value[5:0], zero
  output logic [lls_pkg::STATUS_W-1:0]      m_tuser,   // status[1:0]
  // store_mode register
  input  logic                              cfg_wr_en,
  input  logic [0:0]                        cfg_wr_data
);
  import lls_pkg::*;

  `include "loglog_register_store_max_update_assert.svh"

  cmd_t                   cmd;
  sts_t                   sts;
  logic [OUT_VALUE_W-1:0] out_value;
  status_t                out_status;

  // Sequence the clear sweep, dense update, sparse scan and held-result flush.
  lls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold both stores, the request, the scan pointer and the output register.
  lls_datapath #(
    .INDEX_BITS   (INDEX_BITS),
    .VALUE_BITS   (VALUE_BITS),
    .SPARSE_DEPTH (SPARSE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_action   (s_tuser[0]),
    .in_index    (s_tdata[IN_INDEX_W-1:0]),
    .in_rank     (s_tdata[IN_INDEX_W+IN_RANK_W-1:IN_INDEX_W]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data[0]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_value   (out_value),
    .out_status  (out_status)
  );

  // Pad the value up to whole bytes.
  assign m_tdata = {{(M_TDATA_W-OUT_VALUE_W){1'b0}}, out_value};
  assign m_tuser = out_status;

  // One beat in flight: no second accept right after one.
  `LLS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "accept while busy")

  // Dense beat with a free output lands after the memory read register and the output register.
  `LLS_ASSERT(a_dense_latency,
    (s_tvalid && s_tready && !sts.list_sel && !m_tvalid) |-> ##2 m_tvalid,
    "dense result late")

  // Absent or full results carry a zero value.
  `LLS_ASSERT(a_miss_zero,
    (m_tvalid && (m_tuser != STS_OK)) |-> (m_tdata[OUT_VALUE_W-1:0] == '0),
    "nonzero value on miss")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the dense/sparse rank register store with max update.
module testbench;
  import lls_pkg::*;

  // Sparse list depth as the block is built by default.
  localparam int LIST_DEPTH = 4096;
  localparam int DENSE_SIZE = 1 << IN_INDEX_W;
  localparam logic [IN_INDEX_W-1:0] INDEX_MAX = '1;
  localparam logic [IN_RANK_W-1:0]  RANK_MAX  = '1;
  localparam int PAD_W      = S_TDATA_W - IN_INDEX_W - IN_RANK_W;
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic MODE_DENSE  = 1'b0;
  localparam logic MODE_SPARSE = 1'b1;

  typedef struct {
    logic [OUT_VALUE_W-1:0] value;
    status_t                status;
  } store_result_t;

  // Scoreboard: tracks both stores and the mode, predicts one result per request.
  class rank_scoreboard;
    logic [IN_RANK_W-1:0]  dense_rank [DENSE_SIZE];
    logic [IN_INDEX_W-1:0] list_index [LIST_DEPTH];
    logic [IN_RANK_W-1:0]  list_rank  [LIST_DEPTH];
    int                    list_count;
    logic                  mode_now;
    store_result_t         due_results [$];
    int                    mismatches;

    function new();
      foreach (dense_rank[i]) dense_rank[i] = '0;
      list_count  = 0;
      mode_now    = MODE_DENSE;
      mismatches  = 0;
    endfunction

    function void set_mode(logic m);
      mode_now = m;
    endfunction

    function void take_request(logic act, logic [IN_INDEX_W-1:0] idx,
                               logic [IN_RANK_W-1:0] rank);
      store_result_t r;
      bit            hit;
      r.value  = '0;
      r.status = STS_OK;
      hit      = 1'b0;
      if (mode_now == MODE_DENSE) begin
        if (act == ACT_UPDATE && rank > dense_rank[idx]) dense_rank[idx] = rank;
        r.value = dense_rank[idx];
      end else begin
        // scan the whole list: appends leave it unordered
        for (int k = 0; k < list_count && !hit; k++) begin
          if (list_index[k] == idx) begin
            if (act == ACT_UPDATE && rank > list_rank[k]) list_rank[k] = rank;
            r.value = list_rank[k];
            hit     = 1'b1;
          end
        end
        if (!hit) begin
          if (act == ACT_READ) begin
            r.status = STS_ABSENT;
          end else if (list_count >= LIST_DEPTH) begin
            r.status = STS_FULL;
          end else begin
            list_index[list_count] = idx;
            list_rank[list_count]  = rank;
            list_count++;
            r.value = rank;
          end
        end
      end
      due_results.push_back(r);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata, logic [STATUS_W-1:0] tuser);
      store_result_t r;
      if (due_results.size() == 0) begin
        $error("result beat with nothing outstanding: read_value %0d status %0d",
               tdata[OUT_VALUE_W-1:0], tuser);
        mismatches++;
        return;
      end
      r = due_results.pop_front();
      if (tdata[OUT_VALUE_W-1:0] !== r.value) begin
        $error("read_value: expected %0d, got %0d", r.value, tdata[OUT_VALUE_W-1:0]);
        mismatches++;
      end
      if (tuser !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, tuser);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic [0:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [STATUS_W-1:0]    m_tuser;
  logic                   cfg_wr_en = 1'b0;
  logic [0:0]             cfg_wr_data = '0;

  // idle and stall odds in percent, changed only at phase boundaries
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;

  rank_scoreboard store_sb = new();

  always #2 clk = ~clk;

  loglog_register_store_max_update #(
    .SPARSE_DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Send one request beat. Drop tvalid only while idling, so back-to-back beats
  // keep it high without a second assignment in the same step.
  task automatic send_beat(input logic act, input logic [IN_INDEX_W-1:0] idx,
                           input logic [IN_RANK_W-1:0] rank);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, rank, idx};
    s_tuser  <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    store_sb.take_request(act, idx, rank);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (store_sb.due_results.size() != 0) @(posedge clk);
  endtask

  // Write store_mode; only called with no result outstanding.
  task automatic write_mode(input logic m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    store_sb.set_mode(m);
  endtask

  // Result side: check every accepted beat, then pick the next tready.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) store_sb.check_result(m_tdata, m_tuser);
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Stimulus
  initial begin
    logic [IN_INDEX_W-1:0] dense_seen [$];
    logic [IN_INDEX_W-1:0] sparse_seen [$];
    logic [IN_INDEX_W-1:0] idx;
    logic [IN_RANK_W-1:0]  rank;
    logic                  act;
    logic                  mode;
    int                    set;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // the dense clear after reset keeps s_tready low; the write is taken meanwhile
    write_mode(MODE_DENSE);

    // Directed: dense extremes and an update that is not larger.
    send_beat(ACT_READ,   '0,        '0);
    send_beat(ACT_UPDATE, '0,        RANK_MAX);
    send_beat(ACT_UPDATE, '0,        6'd5);
    send_beat(ACT_READ,   '0,        '0);
    send_beat(ACT_UPDATE, INDEX_MAX, 6'd1);
    send_beat(ACT_READ,   INDEX_MAX, RANK_MAX);
    send_beat(ACT_UPDATE, INDEX_MAX, '0);
    drain();
    write_mode(MODE_SPARSE);
    // Sparse: the list starts empty whatever dense holds, then append, raise, miss.
    send_beat(ACT_READ,   '0,        '0);
    send_beat(ACT_UPDATE, '0,        '0);
    send_beat(ACT_READ,   '0,        RANK_MAX);
    send_beat(ACT_UPDATE, INDEX_MAX, RANK_MAX);
    send_beat(ACT_UPDATE, INDEX_MAX, 6'd10);
    send_beat(ACT_UPDATE, '0,        6'd42);
    send_beat(ACT_READ,   14'd5,     '0);
    drain();
    write_mode(MODE_DENSE);
    // Back in dense mode the dense values must be untouched by sparse traffic.
    send_beat(ACT_READ,   INDEX_MAX, '0);
    send_beat(ACT_READ,   '0,        '0);
    sparse_seen.push_back('0);
    sparse_seen.push_back(INDEX_MAX);
    dense_seen.push_back('0);
    dense_seen.push_back(INDEX_MAX);

    // Random: eight phases, sparse and dense alternating, four idle and stall settings.
    // Fresh sparse updates keep growing the list, so later scans run longer.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      set  = ph / 2;
      mode = (ph % 2 == 0) ? MODE_SPARSE : MODE_DENSE;
      src_idle_pct   = (set == 1) ? 62 : (set == 3) ? 15 : 0;
      sink_stall_pct = (set == 2) ? 62 : (set == 3) ? 15 : 0;
      write_mode(mode);
      for (int n = 0; n < 80; n++) begin
        rank = IN_RANK_W'($urandom_range(RANK_MAX));
        act  = ($urandom_range(99) < 35) ? ACT_READ : ACT_UPDATE;
        if (mode == MODE_SPARSE) begin
          // mostly known indices so scans hit; the rest are fresh
          if ($urandom_range(99) < 60) idx = sparse_seen[$urandom_range(sparse_seen.size() - 1)];
          else idx = IN_INDEX_W'($urandom_range(INDEX_MAX));
          if (act == ACT_UPDATE) sparse_seen.push_back(idx);
        end else begin
          if ($urandom_range(99) < 50) idx = dense_seen[$urandom_range(dense_seen.size() - 1)];
          else idx = IN_INDEX_W'($urandom_range(INDEX_MAX));
          if (act == ACT_UPDATE) dense_seen.push_back(idx);
        end
        send_beat(act, idx, rank);
      end
    end

    drain();
    // leave room for any stray result beat
    repeat (8) @(posedge clk);
    if (store_sb.mismatches == 0 && store_sb.due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/lls_pkg.sv
sv/lls_ctrl.sv
sv/lls_datapath.sv
sv/loglog_register_store_max_update.sv
test/testbench.sv
